FILE: sv/card_bin_longest_prefix_lookup_assert.svh
// Assertion macros for the BIN lookup block.
`ifndef CARD_BIN_LONGEST_PREFIX_LOOKUP_ASSERT_SVH
`define CARD_BIN_LONGEST_PREFIX_LOOKUP_ASSERT_SVH

// Same-cycle implication.
`define CBLPL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CBLPL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/cblpl_pkg.sv
package cblpl_pkg;

  localparam int MaxEntries  = 256;
  localparam int DigitCount  = 9;
  localparam int ShortestBin = 6;
  localparam int NibbleW     = 4;
  localparam int DigitsW     = DigitCount * NibbleW;
  localparam int BinLenW     = 4;
  localparam int CardLenW    = 5;
  localparam int IdxW        = 8;
  localparam int CfgW        = 9;
  localparam int OutcomeW    = 2;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

  typedef enum logic [OutcomeW-1:0] {
    OUT_MATCH   = 2'd0,
    OUT_DEFAULT = 2'd1,
    OUT_NONE    = 2'd2
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [DigitsW-1:0] digits;
    logic [BinLenW-1:0] length;
    logic               is_default;
  } entry_t;

  typedef struct packed {
    logic            present;
    logic [IdxW-1:0] slot;
  } dflt_t;

  typedef struct packed {
    logic               hit;
    logic [BinLenW-1:0] length;
  } match_t;

  // Nibble mask covering the leading len digits; zero for lengths that never match.
  function automatic logic [DigitsW-1:0] prefix_mask(logic [BinLenW-1:0] len);
    logic [DigitsW-1:0] m;
    m = '0;
    if (len >= BinLenW'(ShortestBin) && len <= BinLenW'(DigitCount)) begin
      m = {DigitsW{1'b1}} << {BinLenW'(DigitCount) - len, 2'b00};
    end
    return m;
  endfunction

endpackage

FILE: sv/cblpl_req_if.sv
interface cblpl_req_if import cblpl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                action;
  logic [IdxW-1:0]     entry_index;
  logic [DigitsW-1:0]  bin_digits;
  logic [BinLenW-1:0]  bin_length;
  logic                bin_is_default;
  logic [DigitsW-1:0]  card_digits;
  logic [CardLenW-1:0] card_length;

  modport source (
    output valid, action, entry_index, bin_digits, bin_length, bin_is_default,
           card_digits, card_length,
    input  ready
  );
  modport sink (
    input  valid, action, entry_index, bin_digits, bin_length, bin_is_default,
           card_digits, card_length,
    output ready
  );
endinterface

FILE: sv/cblpl_rsp_if.sv
interface cblpl_rsp_if import cblpl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OutcomeW-1:0] outcome;
  logic [IdxW-1:0]     result_index;
  logic [BinLenW-1:0]  matched_length;

  modport source (output valid, outcome, result_index, matched_length, input ready);
  modport sink (input valid, outcome, result_index, matched_length, output ready);
endinterface

FILE: sv/cblpl_cfg_if.sv
interface cblpl_cfg_if import cblpl_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CfgW-1:0] entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink (input valid, entries_in_use, output ready);
endinterface

FILE: sv/cblpl_table.sv
module cblpl_table import cblpl_pkg::*; #(
  parameter int MAX_ENTRIES = MaxEntries,
  parameter int AW          = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  entry_t          wr_entry_i,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output entry_t          rd_entry_o,
  output dflt_t           dflt_o
);

  entry_t             mem_q [MAX_ENTRIES];
  entry_t             rd_entry_q;
  dflt_t              dflt_q, dflt_d;
  logic [AW+IdxW-1:0] wr_addr_ext;
  logic               wr_ok;

  assign wr_addr_ext = (AW+IdxW)'(wr_idx_i);
  assign wr_ok       = wr_en_i && (32'(wr_idx_i) < 32'(MAX_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_addr_ext[AW-1:0]] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem_q[rd_addr_i];
    end
  end

  always_comb begin
    dflt_d = dflt_q;
    if (wr_ok && wr_entry_i.is_default) begin
      dflt_d.present = 1'b1;
      dflt_d.slot    = wr_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q <= '0;
    end else begin
      dflt_q <= dflt_d;
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign dflt_o     = dflt_q;

endmodule

FILE: sv/cblpl_match.sv
module cblpl_match import cblpl_pkg::*; (
  input  entry_t              entry_i,
  input  logic [DigitsW-1:0]  card_digits_i,
  input  logic [CardLenW-1:0] card_len_i,
  output match_t              match_o
);

  logic [DigitsW-1:0] mask;
  logic               len_ok;
  logic               fits;

  assign mask   = prefix_mask(entry_i.length);
  assign len_ok = (mask != '0);
  assign fits   = CardLenW'(entry_i.length) <= card_len_i;

  assign match_o.hit    = !entry_i.is_default && len_ok && fits &&
                          (((card_digits_i ^ entry_i.digits) & mask) == '0);
  assign match_o.length = entry_i.length;

endmodule

FILE: sv/cblpl_seq.sv
module cblpl_seq import cblpl_pkg::*; #(
  parameter int MAX_ENTRIES = MaxEntries,
  parameter int AW          = 8,
  parameter int CNT_W       = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  cblpl_req_if.sink       req_i,
  cblpl_rsp_if.source     rsp_o,
  input  logic [CfgW-1:0] entries_i,
  input  entry_t          rd_entry_i,
  input  dflt_t           dflt_i,
  output logic            rd_en_o,
  output logic [AW-1:0]   rd_addr_o
);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    rd_cnt_q, rd_cnt_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [CNT_W-1:0]    count_eff;
  logic                pend_q, pend_d;
  logic [IdxW-1:0]     pend_idx_q, pend_idx_d;
  logic [DigitsW-1:0]  card_q, card_d;
  logic [CardLenW-1:0] card_len_q, card_len_d;
  logic [BinLenW-1:0]  best_len_q, best_len_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  logic                out_valid_q, out_valid_d;
  logic [OutcomeW-1:0] outcome_q, outcome_d;
  logic [IdxW-1:0]     res_idx_q, res_idx_d;
  logic [BinLenW-1:0]  res_len_q, res_len_d;
  logic                lookup_start;
  logic                scan_end;
  logic                load;
  match_t              match;

  cblpl_match u_match (
    .entry_i      (rd_entry_i),
    .card_digits_i(card_q),
    .card_len_i   (card_len_q),
    .match_o      (match)
  );

  assign lookup_start = req_i.valid && req_i.ready && (req_i.action == ACT_LOOKUP);
  assign scan_end     = (rd_cnt_q >= count_q) && !pend_q;
  assign load         = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);
  assign count_eff    = (CNT_W'(entries_i) > CNT_W'(MAX_ENTRIES)) ?
                        CNT_W'(MAX_ENTRIES) : CNT_W'(entries_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (lookup_start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_end) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = (state_q == ST_IDLE);
    rd_en_o     = (state_q == ST_SCAN) && (rd_cnt_q < count_q);
    rd_addr_o   = rd_cnt_q[AW-1:0];
  end

  always_comb begin
    rd_cnt_d   = rd_cnt_q;
    count_d    = count_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    card_d     = card_q;
    card_len_d = card_len_q;
    best_len_d = best_len_q;
    best_idx_d = best_idx_q;
    if (lookup_start) begin
      rd_cnt_d   = '0;
      count_d    = count_eff;
      pend_d     = 1'b0;
      card_d     = req_i.card_digits;
      card_len_d = req_i.card_length;
      best_len_d = '0;
      best_idx_d = '0;
    end else if (state_q == ST_SCAN) begin
      pend_d     = rd_en_o;
      pend_idx_d = IdxW'(rd_cnt_q);
      if (rd_en_o) rd_cnt_d = rd_cnt_q + 1'b1;
      // strictly longer wins, so the earliest of equal length stays
      if (pend_q && match.hit && (match.length > best_len_q)) begin
        best_len_d = match.length;
        best_idx_d = pend_idx_q;
      end
    end
  end

  always_comb begin
    out_valid_d = load || (out_valid_q && !rsp_o.ready);
    outcome_d   = outcome_q;
    res_idx_d   = res_idx_q;
    res_len_d   = res_len_q;
    if (load) begin
      if (best_len_q != '0) begin
        outcome_d = OUT_MATCH;
        res_idx_d = best_idx_q;
        res_len_d = best_len_q;
      end else if (dflt_i.present) begin
        outcome_d = OUT_DEFAULT;
        res_idx_d = dflt_i.slot;
        res_len_d = '0;
      end else begin
        outcome_d = OUT_NONE;
        res_idx_d = '0;
        res_len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    card_q     <= card_d;
    card_len_q <= card_len_d;
    best_len_q <= best_len_d;
    best_idx_q <= best_idx_d;
    outcome_q  <= outcome_d;
    res_idx_q  <= res_idx_d;
    res_len_q  <= res_len_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.outcome        = outcome_q;
  assign rsp_o.result_index   = res_idx_q;
  assign rsp_o.matched_length = res_len_q;

endmodule

FILE: sv/card_bin_longest_prefix_lookup.sv
// Card BIN longest-prefix lookup.
// req_i: valid/ready channel. action write stores one table entry at entry_index
//   (slots at or above MAX_ENTRIES are dropped) and records it as default when
//   bin_is_default is set; no response. action lookup searches the first N entries,
//   N = min(entries_in_use, MAX_ENTRIES), for the longest BIN of 9 down to 6 digits
//   matching card_digits, earliest entry on a tie.
// rsp_o: valid/ready channel, one transfer per lookup: outcome, result_index and
//   matched_length, from an output register.
// cfg_i: valid/ready write of entries_in_use; always ready. Write it only while idle.
// Timing: a lookup walks the table one entry per cycle, and req_i.ready is held low
//   from the lookup transfer until its result is loaded into the output register.
// The output register lets a write or the next lookup start while a result waits;
//   a finished lookup holds its result until rsp_o has room.
// Reset: default marker cleared, entries_in_use zero, no response pending. Table
//   contents are unknown until written.
module card_bin_longest_prefix_lookup import cblpl_pkg::*; #(
  parameter int MAX_ENTRIES = MaxEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cblpl_req_if.sink   req_i,
  cblpl_rsp_if.source rsp_o,
  cblpl_cfg_if.sink   cfg_i
);

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = (AW >= CfgW) ? (AW + 1) : CfgW;

  logic [CfgW-1:0] entries_q, entries_d;
  logic            wr_en;
  entry_t          wr_entry;
  entry_t          rd_entry;
  dflt_t           dflt;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;

  assign cfg_i.ready = 1'b1;
  assign entries_d   = (cfg_i.valid && cfg_i.ready) ? cfg_i.entries_in_use : entries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q <= '0;
    end else begin
      entries_q <= entries_d;
    end
  end

  assign wr_en               = req_i.valid && req_i.ready && (req_i.action == ACT_WRITE);
  assign wr_entry.digits     = req_i.bin_digits;
  assign wr_entry.length     = req_i.bin_length;
  assign wr_entry.is_default = req_i.bin_is_default;

  cblpl_table #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .AW         (AW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_idx_i  (req_i.entry_index),
    .wr_entry_i(wr_entry),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_entry_o(rd_entry),
    .dflt_o    (dflt)
  );

  cblpl_seq #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .AW         (AW),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .rsp_o     (rsp_o),
    .entries_i (entries_q),
    .rd_entry_i(rd_entry),
    .dflt_i    (dflt),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr)
  );

`include "card_bin_longest_prefix_lookup_assert.svh"

  `CBLPL_ASSERT_NXT(a_busy_after_lookup, req_i.valid && req_i.ready && req_i.action == ACT_LOOKUP, !req_i.ready, "request taken during lookup")
  `CBLPL_ASSERT_IMP(a_match_len, rsp_o.valid && rsp_o.outcome == OUT_MATCH, rsp_o.matched_length >= BinLenW'(ShortestBin) && rsp_o.matched_length <= BinLenW'(DigitCount), "match length out of range")
  `CBLPL_ASSERT_IMP(a_miss_len, rsp_o.valid && rsp_o.outcome != OUT_MATCH, rsp_o.matched_length == '0, "length set without match")
  `CBLPL_ASSERT_IMP(a_none_index, rsp_o.valid && rsp_o.outcome == OUT_NONE, rsp_o.result_index == '0, "index set without default")

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cblpl_pkg::*;

  localparam int StallLimit = 5000;
  localparam int LongHold   = 1000;
  localparam int TailCycles = MaxEntries + 8;
  localparam int PoolSize   = 6;
  localparam int PhaseCount = 12;
  localparam int PhaseInUse [PhaseCount] = '{3, 16, 0, 256, 1, 40, 511, 8, 24, 2, 12, 64};

  typedef struct {
    action_e             act;
    logic [IdxW-1:0]     slot;
    logic [DigitsW-1:0]  bin;
    logic [BinLenW-1:0]  blen;
    logic                dflt;
    logic [DigitsW-1:0]  card;
    logic [CardLenW-1:0] clen;
  } bin_req_t;

  typedef struct {
    outcome_e           outcome;
    logic [IdxW-1:0]    slot;
    logic [BinLenW-1:0] mlen;
  } bin_rsp_t;

  logic clk_i;
  logic rst_ni;

  cblpl_req_if req_if ();
  cblpl_rsp_if rsp_if ();
  cblpl_cfg_if cfg_if ();

  card_bin_longest_prefix_lookup dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  bin_req_t           pending_reqs [$];
  bin_rsp_t           expected_rsps [$];
  bin_req_t           cur_req;

  // predictor state, updated on accepted transfers
  entry_t             model_tab [MaxEntries];
  dflt_t              model_dflt = '0;
  int                 model_in_use = 0;

  // stimulus-side copy of the table, updated when items are queued
  entry_t             shadow_tab [MaxEntries];
  logic [DigitsW-1:0] base_pool [PoolSize];

  int reqs_queued  = 0;
  int reqs_taken   = 0;
  int rsps_seen    = 0;
  int cfg_writes   = 0;
  int stall_cycles = 0;
  int n_errors     = 0;
  int req_gap      = 0;
  int rsp_gap      = 0;
  int hold_cnt     = 0;
  bit hold_done    = 0;
  bit quiet        = 0;
  logic req_took   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic apply_request(bin_req_t r);
    int       n;
    int       sh;
    bit       hit;
    bin_rsp_t rsp;
    if (r.act == ACT_WRITE) begin
      model_tab[r.slot] = '{digits: r.bin, length: r.blen, is_default: r.dflt};
      if (r.dflt) begin
        model_dflt = '{present: 1'b1, slot: r.slot};
      end
    end else begin
      n = (model_in_use > MaxEntries) ? MaxEntries : model_in_use;
      hit = 1'b0;
      for (int len = DigitCount; len >= ShortestBin && !hit; len--) begin
        if (len > r.clen) continue;
        sh = NibbleW * (DigitCount - len);
        for (int i = 0; i < n && !hit; i++) begin
          if (!model_tab[i].is_default && model_tab[i].length == len &&
              (r.card >> sh) == (model_tab[i].digits >> sh)) begin
            hit = 1'b1;
            rsp = '{OUT_MATCH, IdxW'(i), BinLenW'(len)};
          end
        end
      end
      if (!hit) begin
        if (model_dflt.present) begin
          rsp = '{OUT_DEFAULT, model_dflt.slot, '0};
        end else begin
          rsp = '{OUT_NONE, '0, '0};
        end
      end
      expected_rsps.push_back(rsp);
    end
  endtask

  // monitor: transfers on all three channels, result checking
  always @(posedge clk_i) begin
    bin_rsp_t want;
    bit       moved;
    if (!rst_ni) begin
      req_took <= 1'b0;
    end else begin
      moved = 1'b0;
      req_took <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        apply_request(cur_req);
        reqs_taken++;
        moved = 1'b1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        model_in_use = cfg_if.entries_in_use;
        cfg_writes++;
        moved = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        rsps_seen++;
        moved = 1'b1;
        if (expected_rsps.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("unexpected result: outcome %0d index %0d length %0d",
                     rsp_if.outcome, rsp_if.result_index, rsp_if.matched_length);
          end
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_if.outcome !== want.outcome || rsp_if.result_index !== want.slot ||
              rsp_if.matched_length !== want.mlen) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("mismatch on result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       rsps_seen, want.outcome, want.slot, want.mlen, rsp_if.outcome,
                       rsp_if.result_index, rsp_if.matched_length);
            end
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
    end
  end

  // request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_took) begin
      if (req_gap > 0) begin
        req_gap--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        req_gap = $urandom_range(0, 6);
        req_if.valid <= 1'b0;
      end else begin
        cur_req = pending_reqs.pop_front();
        req_if.action         <= cur_req.act;
        req_if.entry_index    <= cur_req.slot;
        req_if.bin_digits     <= cur_req.bin;
        req_if.bin_length     <= cur_req.blen;
        req_if.bin_is_default <= cur_req.dflt;
        req_if.card_digits    <= cur_req.card;
        req_if.card_length    <= cur_req.clen;
        req_if.valid          <= 1'b1;
      end
    end
  end

  // result receiver, with one long hold-off while requests are still queued
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      rsp_if.ready <= 1'b0;
    end else if (!hold_done && rsps_seen >= 300 && reqs_queued - reqs_taken > 20) begin
      hold_done = 1'b1;
      hold_cnt = LongHold - 1;
      rsp_if.ready <= 1'b0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rsp_gap = $urandom_range(0, 6);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  initial begin
    while (stall_cycles < StallLimit) @(negedge clk_i);
    $display("card_bin_longest_prefix_lookup regression: fail");
    $finish;
  end

  function automatic logic [DigitsW-1:0] random_word();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[DigitsW-1:0];
  endfunction

  // keep the leading digits, replace the rest with random ones
  function automatic logic [DigitsW-1:0] scramble_tail(logic [DigitsW-1:0] d, int keep);
    for (int j = keep; j < DigitCount; j++) begin
      d[NibbleW*(DigitCount-1-j) +: NibbleW] =
        NibbleW'(($urandom_range(0, 9) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9));
    end
    return d;
  endfunction

  function automatic logic [DigitsW-1:0] random_bin();
    if ($urandom_range(0, 9) == 0) return random_word();
    return scramble_tail(base_pool[$urandom_range(0, PoolSize-1)], $urandom_range(6, 9));
  endfunction

  function automatic int random_len();
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(6, 9);
  endfunction

  function automatic int random_card_len();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(9, 19);
  endfunction

  function automatic bin_req_t write_item(int slot, logic [DigitsW-1:0] bin, int len, bit dflt);
    bin_req_t r;
    r = '{ACT_WRITE, IdxW'(slot), bin, BinLenW'(len), dflt, '0, '0};
    return r;
  endfunction

  function automatic bin_req_t lookup_item(logic [DigitsW-1:0] card, int clen);
    bin_req_t r;
    r = '{ACT_LOOKUP, '0, '0, '0, 1'b0, card, CardLenW'(clen)};
    return r;
  endfunction

  function automatic bin_req_t random_item(int span);
    bin_req_t r;
    int       pick;
    if ($urandom_range(0, 99) < 30) begin
      pick = (span == 0 || $urandom_range(0, 7) == 0) ? $urandom_range(0, MaxEntries-1)
                                                       : $urandom_range(0, span-1);
      r = write_item(pick, random_bin(), random_len(), $urandom_range(0, 19) == 0);
    end else if (span > 0 && $urandom_range(0, 9) < 7) begin
      pick = $urandom_range(0, span-1);
      r = lookup_item(scramble_tail(shadow_tab[pick].digits, $urandom_range(5, 9)),
                      random_card_len());
    end else if ($urandom_range(0, 1) == 0) begin
      r = lookup_item(random_word(), random_card_len());
    end else begin
      r = lookup_item(scramble_tail(base_pool[$urandom_range(0, PoolSize-1)],
                                    $urandom_range(3, 9)), random_card_len());
    end
    return r;
  endfunction

  task automatic post(bin_req_t r);
    pending_reqs.push_back(r);
    reqs_queued++;
    if (r.act == ACT_WRITE) begin
      shadow_tab[r.slot] = '{digits: r.bin, length: r.blen, is_default: r.dflt};
    end
  endtask

  task automatic drain();
    while (reqs_taken != reqs_queued || expected_rsps.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_in_use(int value);
    int target;
    drain();
    repeat (8) @(negedge clk_i);
    target = cfg_writes + 1;
    cfg_if.entries_in_use <= CfgW'(value);
    cfg_if.valid <= 1'b1;
    do @(negedge clk_i); while (cfg_writes != target);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    int span;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.action = ACT_WRITE;
    req_if.entry_index = '0;
    req_if.bin_digits = '0;
    req_if.bin_length = '0;
    req_if.bin_is_default = 1'b0;
    req_if.card_digits = '0;
    req_if.card_length = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.entries_in_use = '0;
    for (int k = 0; k < PoolSize; k++) begin
      base_pool[k] = scramble_tail('0, 0);
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty search, no default, then a default loaded
    post(lookup_item(36'h123456789, 19));
    post(lookup_item('0, 0));
    post(write_item(200, 36'h555555555, 9, 1'b1));
    post(lookup_item(36'h555555555, 9));

    // load every slot so any entry count is legal from here on
    for (int k = 0; k < MaxEntries; k++) begin
      post(write_item(k, random_bin(), random_len(), $urandom_range(0, 31) == 0));
    end

    set_in_use(8);
    post(write_item(0, 36'h123456789, 9, 1'b0));
    post(write_item(1, 36'h123456000, 6, 1'b0));
    post(write_item(2, 36'h123456700, 7, 1'b0));
    post(write_item(3, 36'h123456999, 6, 1'b0));
    post(write_item(4, 36'h999999999, 9, 1'b1));
    post(write_item(5, 36'hFFFFFFFFF, 9, 1'b0));
    post(write_item(6, 36'h000000000, 15, 1'b0));
    post(write_item(7, 36'h000000000, 5, 1'b0));
    post(lookup_item(36'h123456789, 19));
    post(lookup_item(36'h123456789, 8));
    post(lookup_item(36'h123456111, 6));
    post(lookup_item(36'h999999999, 19));
    post(lookup_item(36'hFFFFFFFFF, 31));
    post(lookup_item(36'h000000000, 0));
    post(lookup_item(36'h000000000, 19));
    // default slot rewritten as a plain entry keeps the default marker
    post(write_item(4, 36'h999999999, 9, 1'b0));
    post(lookup_item(36'h999999999, 9));
    post(lookup_item(36'h000000001, 9));
    post(write_item(7, 36'h000000000, 5, 1'b1));
    post(lookup_item(36'h555555555, 19));

    for (int p = 0; p < PhaseCount; p++) begin
      span = (PhaseInUse[p] > MaxEntries) ? MaxEntries : PhaseInUse[p];
      set_in_use(PhaseInUse[p]);
      if (p == PhaseCount - 1) quiet = 1'b1;
      for (int k = 0; k < ((PhaseInUse[p] > 64) ? 40 : 100); k++) begin
        post(random_item(span));
      end
    end

    drain();
    repeat (TailCycles) @(negedge clk_i);
    if (n_errors == 0) begin
      $display("card_bin_longest_prefix_lookup regression: pass");
    end else begin
      $display("card_bin_longest_prefix_lookup regression: fail");
    end
    $finish;
  end

endmodule
